>>> rtl/tss_pkg.sv
package tss_pkg;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_REPORT     = 2'd2,
    OP_FRAME      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_FRAME_PERIOD = 3'd0,
    CFG_SLOT_MIN     = 3'd1,
    CFG_SLOT_MAX     = 3'd2,
    CFG_GUARD        = 3'd3,
    CFG_BASE_SLOT    = 3'd4,
    CFG_OVERLOAD     = 3'd5,
    CFG_IDLE         = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  trk;
    logic [1:0]  prio;
    logic [9:0]  dur;
    logic [31:0] last_tx;
    logic [6:0]  succ;
    logic [7:0]  retries;
    logic        retx;
  } ent_t;

  localparam logic [1:0]  PRIO_LOW       = 2'd1;
  localparam logic [1:0]  PRIO_HIGH      = 2'd3;
  localparam logic [6:0]  SUCC_INIT      = 7'd100;
  localparam logic [10:0] REPORT_BASE_US = 11'd328;
  localparam logic [31:0] WAIT_CAP_US    = 32'd50000;
  localparam logic [9:0]  WAIT_CAP_PTS   = 10'd500;
  // floor(x/100) = (x * RECIP_100) >> 24 for x below 50000
  localparam logic [17:0] RECIP_100      = 18'd167773;
  // floor(x/5) for x below 4096, floor(x/10) for x below 16384, both >> 16
  localparam logic [13:0] RECIP_5        = 14'd13108;
  localparam logic [12:0] RECIP_10       = 13'd6554;

endpackage

>>> rtl/tdma_slot_scheduler_unit.sv
// channel  | ports                                              | dir
// input    | in_valid in_stall in_op in_now_us in_tracker ...   | in
// result   | out_valid out_stall out_status ... out_frame_count  | out
// config   | cfg_valid cfg_ready cfg_index cfg_data             | in
//
// one word at a time; each item runs the phases that its op needs
// (lookup sweep, sum sweep, 22-step utilisation divide, rescale sweep,
// selection sweep over the entry memory)
// reset clears the active flags and the active, sweep and frame counters, no clearing pass
// a finished result sits in the output register while the next word is taken;
// the sequencer waits in its last state only when that register is still full
module tdma_slot_scheduler_unit
  import tss_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_now_us,
  input  logic [7:0]  in_tracker,
  input  logic [1:0]  in_prio,
  input  logic        in_tx_ok,
  input  logic [15:0] in_latency,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_index,
  output logic        out_next_valid,
  output logic [3:0]  out_pick_slot,
  output logic [7:0]  out_next_tracker,
  output logic [9:0]  out_next_duration,
  output logic [7:0]  out_util_pct,
  output logic [15:0] out_avg_latency,
  output logic [15:0] out_max_latency,
  output logic [15:0] out_frame_left_us,
  output logic [31:0] out_frame_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW   = $clog2(NUM_SLOTS + 1);
  localparam int SUMW = $clog2(NUM_SLOTS * 1023 + 1);
  localparam int NUMW = SUMW + 7;
  localparam int DCW  = $clog2(NUMW + 1);
  localparam logic [IW:0] LAST = (IW + 1)'(NUM_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_RDK, S_MODK, S_SUM, S_DIV, S_RESC, S_SEL, S_DONE
  } state_t;

  // configuration registers
  logic [15:0] period_r;
  logic [9:0]  smin_r, smax_r, base_r;
  logic [7:0]  guard_r, over_r, idle_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd5000;
      smin_r   <= 10'd200;
      smax_r   <= 10'd1000;
      guard_r  <= 8'd50;
      base_r   <= 10'd300;
      over_r   <= 8'd90;
      idle_r   <= 8'd70;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_PERIOD: period_r <= cfg_data;
        CFG_SLOT_MIN:     smin_r   <= cfg_data[9:0];
        CFG_SLOT_MAX:     smax_r   <= cfg_data[9:0];
        CFG_GUARD:        guard_r  <= cfg_data[7:0];
        CFG_BASE_SLOT:    base_r   <= cfg_data[9:0];
        CFG_OVERLOAD:     over_r   <= cfg_data[7:0];
        CFG_IDLE:         idle_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // entry memory, one read and one write port, registered read
  ent_t          mem [NUM_SLOTS];
  ent_t          rdata_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  ent_t          wdata;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wdata;
    rdata_r <= mem[rd_addr];
  end

  state_t         state_r;
  logic [NUM_SLOTS-1:0] act_r, ever_r;
  logic [CW-1:0]  act_cnt_r;
  logic [IW:0]    cnt_r;
  logic [1:0]     op_r, prio_r;
  logic [31:0]    now_r;
  logic [7:0]     trk_r;
  logic           ok_r;
  logic [15:0]    lat_r;
  logic [IW-1:0]  k_r;
  logic           found_r;
  logic [1:0]     status_r;
  logic [SUMW-1:0] sum_r;
  logic [NUMW-1:0] dq_r;
  logic [16:0]    rem_r;
  logic [DCW-1:0] dcnt_r;
  logic [7:0]     util_r;
  logic [15:0]    avg_r, max_r;
  logic [31:0]    fbegin_r, fcount_r;
  logic           best_v_r;
  logic [10:0]    best_sc_r;
  logic [IW-1:0]  best_i_r;
  logic [7:0]     best_trk_r;
  logic [9:0]     best_dur_r;
  logic           out_valid_r;

  // sweep bookkeeping: read issued at cnt, processed in the next cycle
  logic [IW-1:0] pidx;
  logic          pvalid, sweep_end;
  assign pidx      = IW'(cnt_r - 1'b1);
  assign pvalid    = (cnt_r != '0);
  assign sweep_end = (cnt_r == LAST);

  always_comb begin
    rd_addr = cnt_r[IW-1:0];
    if (state_r == S_RDK) rd_addr = k_r;
  end

  // first free entry
  logic          free_v;
  logic [IW-1:0] free_i;
  always_comb begin
    free_v = 1'b0;
    free_i = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_v = 1'b1;
        free_i = IW'(i);
      end
    end
  end

  // report update of the addressed entry
  ent_t        old_e;
  logic [11:0] succ_t;
  logic [6:0]  succ_new;
  logic [10:0] rep_d, rep_dc;
  logic [19:0] avg_t;
  always_comb begin
    old_e = rdata_r;
    if (!ever_r[k_r]) begin
      old_e.retries = '0;
      old_e.retx    = 1'b0;
    end
    succ_t   = 12'(rdata_r.succ) * 12'd15 + (ok_r ? 12'd100 : 12'd0);
    succ_new = succ_t[10:4];
    rep_d    = REPORT_BASE_US + 11'(guard_r);
    if (succ_new < 7'd90)      rep_d = rep_d + 11'd100;
    else if (succ_new < 7'd95) rep_d = rep_d + 11'd50;
    rep_dc = rep_d;
    if (rep_dc < 11'(smin_r)) rep_dc = 11'(smin_r);
    if (rep_dc > 11'(smax_r)) rep_dc = 11'(smax_r);
    avg_t = 20'(avg_r) * 20'd15 + 20'(lat_r);
  end

  // rescale of one entry
  logic [11:0] shr_x;
  logic [25:0] shr_p;
  logic [9:0]  shr_d;
  logic [13:0] grw_x;
  logic [26:0] grw_p;
  logic [10:0] grw_d;
  logic [9:0]  resc_d;
  always_comb begin
    shr_x = {rdata_r.dur, 2'b00};
    shr_p = 26'(shr_x) * 26'(RECIP_5);
    shr_d = shr_p[25:16];
    if (shr_d < smin_r) shr_d = smin_r;
    grw_x = 14'(rdata_r.dur) * 14'd11;
    grw_p = 27'(grw_x) * 27'(RECIP_10);
    grw_d = grw_p[26:16];
    if (grw_d > 11'(smax_r)) grw_d = 11'(smax_r);
    if (grw_d > 11'd1023)    grw_d = 11'd1023;
    resc_d = rdata_r.dur;
    if (act_r[pidx] && rdata_r.prio == PRIO_LOW && util_r > over_r) resc_d = shr_d;
    if (act_r[pidx] && rdata_r.prio == PRIO_HIGH && util_r < idle_r) resc_d = grw_d[9:0];
  end

  // score of one entry
  logic [31:0] wait_us;
  logic [33:0] wait_p;
  logic [9:0]  wait_pts;
  logic [10:0] score;
  always_comb begin
    wait_us  = now_r - rdata_r.last_tx;
    wait_p   = 34'(wait_us[15:0]) * 34'(RECIP_100);
    wait_pts = (wait_us >= WAIT_CAP_US) ? WAIT_CAP_PTS : wait_p[33:24];
    score    = (rdata_r.retx ? 11'd1000 : 11'd0) + 11'(rdata_r.prio) * 11'd100
             + 11'(wait_pts);
  end

  // divider step
  logic [16:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_r[15:0], dq_r[NUMW-1]};
  assign rem_ge = (rem_sh >= {1'b0, period_r});

  logic [31:0] f_elapsed;
  assign f_elapsed = now_r - fbegin_r;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k_r;
    wdata   = old_e;
    case (state_r)
      S_MODK: begin
        if (op_r == OP_REGISTER) begin
          wr_en         = 1'b1;
          wdata.trk     = trk_r;
          wdata.prio    = prio_r;
          wdata.dur     = base_r;
          wdata.last_tx = now_r;
          wdata.succ    = SUCC_INIT;
        end else if (op_r == OP_REPORT) begin
          wr_en         = 1'b1;
          wdata.succ    = succ_new;
          wdata.last_tx = now_r;
          wdata.dur     = rep_dc[9:0];
          wdata.retx    = !ok_r;
          if (ok_r) wdata.retries = '0;
          else if (old_e.retries != 8'hFF) wdata.retries = old_e.retries + 8'd1;
        end
      end
      S_RESC: begin
        wr_en     = pvalid;
        wr_addr   = pidx;
        wdata     = rdata_r;
        wdata.dur = resc_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= '0;
      ever_r      <= '0;
      act_cnt_r   <= '0;
      cnt_r       <= '0;
      util_r      <= '0;
      avg_r       <= '0;
      max_r       <= '0;
      fbegin_r    <= '0;
      fcount_r    <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      best_v_r    <= 1'b0;
    end else begin
      // the final state reloads the register itself
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_op;
            now_r    <= in_now_us;
            trk_r    <= in_tracker;
            prio_r   <= in_prio;
            ok_r     <= in_tx_ok;
            lat_r    <= in_latency;
            cnt_r    <= '0;
            found_r  <= 1'b0;
            status_r <= (in_op == OP_REGISTER && !free_v) ? ST_FULL : ST_DONE;
            k_r      <= free_i;
            case (in_op)
              OP_REGISTER: begin
                state_r <= free_v ? S_RDK : S_SEL;
              end
              OP_FRAME: begin
                fbegin_r <= in_now_us;
                fcount_r <= fcount_r + 32'd1;
                state_r  <= S_SEL;
              end
              default: state_r <= S_FIND;
            endcase
          end
        end
        S_FIND: begin
          if (pvalid && !found_r && act_r[pidx] && rdata_r.trk == trk_r) begin
            found_r <= 1'b1;
            k_r     <= pidx;
          end
          if (sweep_end) begin
            cnt_r <= '0;
            if (found_r || (act_r[pidx] && rdata_r.trk == trk_r)) begin
              state_r <= S_RDK;
            end else begin
              status_r <= ST_NOT_FOUND;
              state_r  <= (op_r == OP_UNREGISTER) ? S_SUM : S_SEL;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_RDK: state_r <= S_MODK;
        S_MODK: begin
          cnt_r <= '0;
          case (op_r)
            OP_REGISTER: begin
              act_r[k_r]  <= 1'b1;
              ever_r[k_r] <= 1'b1;
              act_cnt_r   <= act_cnt_r + 1'b1;
              state_r     <= S_SUM;
            end
            OP_UNREGISTER: begin
              act_r[k_r] <= 1'b0;
              if (act_cnt_r != '0) act_cnt_r <= act_cnt_r - 1'b1;
              state_r <= S_SUM;
            end
            default: begin
              if (lat_r > max_r) max_r <= lat_r;
              avg_r   <= avg_t[19:4];
              state_r <= S_SEL;
            end
          endcase
        end
        S_SUM: begin
          if (!pvalid) sum_r <= '0;
          else if (act_r[pidx]) sum_r <= sum_r + SUMW'(rdata_r.dur);
          if (sweep_end) begin
            cnt_r <= '0;
            if (act_cnt_r == '0) begin
              state_r <= S_SEL;
            end else if (period_r == 16'd0) begin
              util_r  <= 8'd255;
              state_r <= S_RESC;
            end else begin
              dq_r    <= (NUMW'(sum_r) + (act_r[pidx] ? NUMW'(rdata_r.dur) : '0))
                         * NUMW'(100);
              rem_r   <= '0;
              dcnt_r  <= '0;
              state_r <= S_DIV;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          rem_r  <= rem_ge ? (rem_sh - {1'b0, period_r}) : rem_sh;
          dq_r   <= {dq_r[NUMW-2:0], rem_ge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCW'(NUMW)) begin
            util_r  <= (dq_r > NUMW'(255)) ? 8'd255 : dq_r[7:0];
            state_r <= S_RESC;
          end
        end
        S_RESC: begin
          if (sweep_end) begin
            cnt_r   <= '0;
            state_r <= S_SEL;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SEL: begin
          if (!pvalid) begin
            best_v_r <= 1'b0;
          end else if (act_r[pidx] && (!best_v_r || score > best_sc_r)) begin
            best_v_r   <= 1'b1;
            best_sc_r  <= score;
            best_i_r   <= pidx;
            best_trk_r <= rdata_r.trk;
            best_dur_r <= rdata_r.dur;
          end
          if (sweep_end) state_r <= S_DONE;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r       <= 1'b1;
            out_status        <= status_r;
            out_slot_index    <= (status_r == ST_DONE && op_r != OP_FRAME) ? 4'(k_r) : 4'd0;
            out_next_valid    <= best_v_r;
            out_pick_slot     <= best_v_r ? 4'(best_i_r) : 4'd0;
            out_next_tracker  <= best_v_r ? best_trk_r : 8'd0;
            out_next_duration <= best_v_r ? best_dur_r : 10'd0;
            out_util_pct      <= util_r;
            out_avg_latency   <= avg_r;
            out_max_latency   <= max_r;
            out_frame_left_us <= (f_elapsed >= 32'(period_r)) ? 16'd0
                                 : period_r - f_elapsed[15:0];
            out_frame_count   <= fcount_r;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    act_cnt_r == CW'($countones(act_r)))
    else $error("active count out of step with active flags");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("sequencer idle right after accepting a word");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the final state");
  a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_MODK || state_r == S_RESC))
    else $error("entry memory written outside update phases");
`endif

endmodule

>>> tb/tb_tdma_slot_scheduler_unit.sv
module tb_tdma_slot_scheduler_unit;
  import tss_pkg::*;

  localparam int NSLOT = 16;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    status_t     status;
    logic [3:0]  slot_index;
    logic        next_valid;
    logic [3:0]  pick_slot;
    logic [7:0]  next_tracker;
    logic [9:0]  next_duration;
    logic [7:0]  util_pct;
    logic [15:0] avg_latency;
    logic [15:0] max_latency;
    logic [15:0] frame_left_us;
    logic [31:0] frame_count;
  } sched_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [31:0] in_now_us;
  logic [7:0]  in_tracker;
  logic [1:0]  in_prio;
  logic        in_tx_ok;
  logic [15:0] in_latency;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [3:0]  out_slot_index;
  logic        out_next_valid;
  logic [3:0]  out_pick_slot;
  logic [7:0]  out_next_tracker;
  logic [9:0]  out_next_duration;
  logic [7:0]  out_util_pct;
  logic [15:0] out_avg_latency;
  logic [15:0] out_max_latency;
  logic [15:0] out_frame_left_us;
  logic [31:0] out_frame_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  tdma_slot_scheduler_unit #(.NUM_SLOTS(NSLOT)) u_dut (.*);

  // scheduler mirror: slot table, global counters and register copies
  bit          slot_act[NSLOT];
  bit [7:0]    slot_trk[NSLOT];
  bit [1:0]    slot_pri[NSLOT];
  int unsigned slot_dur[NSLOT];
  int unsigned slot_last[NSLOT];
  int unsigned slot_succ[NSLOT];
  int unsigned slot_retries[NSLOT];
  bit          slot_retx[NSLOT];
  int unsigned n_active, frame_origin_us, frames_seen;
  int unsigned util_now, lat_avg, lat_max;
  int unsigned period_us, min_us, max_us, guard, base_us, over_pct, idle_thr;

  sched_word_t pending_words[$];
  int          err_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          rx_hold_left;
  int          quiet_cycles;
  int unsigned clock_us;

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver back-pressure: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall    <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // result checker: each accepted word against the oldest prediction
  always @(posedge clk) begin
    sched_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        err_count++;
      end else begin
        e = pending_words.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); err_count++;
        end
        if (out_slot_index !== e.slot_index) begin
          $error("slot_index exp %0d got %0d", e.slot_index, out_slot_index); err_count++;
        end
        if (out_next_valid !== e.next_valid) begin
          $error("next_valid exp %0d got %0d", e.next_valid, out_next_valid); err_count++;
        end
        if (out_pick_slot !== e.pick_slot) begin
          $error("pick_slot exp %0d got %0d", e.pick_slot, out_pick_slot); err_count++;
        end
        if (out_next_tracker !== e.next_tracker) begin
          $error("next_tracker exp %0d got %0d", e.next_tracker, out_next_tracker);
          err_count++;
        end
        if (out_next_duration !== e.next_duration) begin
          $error("next_duration exp %0d got %0d", e.next_duration, out_next_duration);
          err_count++;
        end
        if (out_util_pct !== e.util_pct) begin
          $error("util_pct exp %0d got %0d", e.util_pct, out_util_pct); err_count++;
        end
        if (out_avg_latency !== e.avg_latency) begin
          $error("avg_latency exp %0d got %0d", e.avg_latency, out_avg_latency); err_count++;
        end
        if (out_max_latency !== e.max_latency) begin
          $error("max_latency exp %0d got %0d", e.max_latency, out_max_latency); err_count++;
        end
        if (out_frame_left_us !== e.frame_left_us) begin
          $error("frame_left_us exp %0d got %0d", e.frame_left_us, out_frame_left_us);
          err_count++;
        end
        if (out_frame_count !== e.frame_count) begin
          $error("frame_count exp %0d got %0d", e.frame_count, out_frame_count); err_count++;
        end
      end
    end
  end

  // utilisation step after register and unregister
  function automatic void rebalance_table();
    int unsigned sum, util, d;
    sum = 0;
    if (n_active == 0) return;
    for (int i = 0; i < NSLOT; i++) if (slot_act[i]) sum += slot_dur[i];
    if (period_us == 0) util = 255;
    else begin
      util = (sum * 100) / period_us;
      if (util > 255) util = 255;
    end
    util_now = util;
    // overload shrinks low priority slots to 80 percent
    if (util > over_pct) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_act[i] && slot_pri[i] == PRIO_LOW) begin
          d = (slot_dur[i] * 80) / 100;
          if (d < min_us) d = min_us;
          slot_dur[i] = d & 'h3FF;
        end
      end
    end
    // idle grows high priority slots to 110 percent, after any shrink
    if (util < idle_thr) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_act[i] && slot_pri[i] == PRIO_HIGH) begin
          d = (slot_dur[i] * 110) / 100;
          if (d > max_us) d = max_us;
          if (d > 1023) d = 1023;
          slot_dur[i] = d;
        end
      end
    end
  endfunction

  function automatic int lookup_tracker(bit [7:0] id);
    for (int i = 0; i < NSLOT; i++) if (slot_act[i] && slot_trk[i] == id) return i;
    return -1;
  endfunction

  // applies one operation to the mirror and returns the word it produces
  function automatic sched_word_t schedule_op(op_t op, int unsigned now, bit [7:0] id,
                                              bit [1:0] pri, bit ok, int unsigned lat);
    sched_word_t w;
    int k, best;
    int unsigned r, d, sc, wt, best_sc, elapsed;
    w.status     = ST_DONE;
    w.slot_index = '0;
    best         = -1;
    best_sc      = 0;
    case (op)
      OP_REGISTER: begin
        k = -1;
        if (n_active < NSLOT) begin
          for (int i = 0; i < NSLOT; i++) if (!slot_act[i] && k < 0) k = i;
        end
        if (k < 0) w.status = ST_FULL;
        else begin
          // retries and retransmit flag of a reused entry are kept
          slot_trk[k]  = id;
          slot_pri[k]  = pri;
          slot_dur[k]  = base_us;
          slot_succ[k] = 100;
          slot_act[k]  = 1'b1;
          slot_last[k] = now;
          n_active++;
          w.slot_index = 4'(k);
          rebalance_table();
        end
      end
      OP_UNREGISTER: begin
        k = lookup_tracker(id);
        if (k < 0) w.status = ST_NOT_FOUND;
        else begin
          slot_act[k] = 1'b0;
          if (n_active > 0) n_active--;
          w.slot_index = 4'(k);
        end
        rebalance_table();
      end
      OP_REPORT: begin
        k = lookup_tracker(id);
        if (k < 0) w.status = ST_NOT_FOUND;
        else begin
          if (ok) begin
            r = (slot_succ[k] * 15 + 100) / 16;
            slot_retx[k]    = 1'b0;
            slot_retries[k] = 0;
          end else begin
            r = (slot_succ[k] * 15) / 16;
            slot_retx[k] = 1'b1;
            if (slot_retries[k] < 255) slot_retries[k]++;
          end
          slot_succ[k] = r & 'h7F;
          slot_last[k] = now;
          d = 328 + guard;
          if (slot_succ[k] < 90) d += 100;
          else if (slot_succ[k] < 95) d += 50;
          if (d < min_us) d = min_us;
          if (d > max_us) d = max_us;
          slot_dur[k] = d & 'h3FF;
          if (lat > lat_max) lat_max = lat;
          lat_avg = ((lat_avg * 15 + lat) / 16) & 'hFFFF;
          w.slot_index = 4'(k);
        end
      end
      default: begin
        frame_origin_us = now;
        frames_seen++;
      end
    endcase
    // strictly highest score wins, lowest index on ties
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_act[i]) begin
        sc = slot_retx[i] ? 1000 : 0;
        sc += slot_pri[i] * 100;
        wt = (now - slot_last[i]) / 100;
        sc += (wt > 500) ? 500 : wt;
        if (best < 0 || sc > best_sc) begin
          best_sc = sc;
          best    = i;
        end
      end
    end
    w.next_valid    = (best >= 0);
    w.pick_slot     = (best >= 0) ? 4'(best) : 4'd0;
    w.next_tracker  = (best >= 0) ? slot_trk[best] : 8'd0;
    w.next_duration = (best >= 0) ? 10'(slot_dur[best]) : 10'd0;
    w.util_pct      = 8'(util_now);
    w.avg_latency   = 16'(lat_avg);
    w.max_latency   = 16'(lat_max);
    elapsed         = now - frame_origin_us;
    w.frame_left_us = (elapsed >= period_us) ? 16'd0 : 16'(period_us - elapsed);
    w.frame_count   = frames_seen;
    return w;
  endfunction

  // offer one word, wait for the handshake, then maybe leave a gap
  task automatic send_op(op_t op, int unsigned now, bit [7:0] id, bit [1:0] pri,
                         bit ok, bit [15:0] lat);
    @(negedge clk);
    in_valid   = 1'b1;
    in_op      = op;
    in_now_us  = now;
    in_tracker = id;
    in_prio    = pri;
    in_tx_ok   = ok;
    in_latency = lat;
    do @(posedge clk); while (in_stall);
    pending_words.push_back(schedule_op(op, now, id, pri, ok, lat));
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 120)) @(negedge clk);
    end
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_words.size() == 0);
    // sequencer finishes its last sweep well within this
    repeat (4 * NSLOT + 40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_PERIOD: period_us = value;
      CFG_SLOT_MIN:     min_us    = value & 'h3FF;
      CFG_SLOT_MAX:     max_us    = value & 'h3FF;
      CFG_GUARD:        guard     = value & 'hFF;
      CFG_BASE_SLOT:    base_us   = value & 'h3FF;
      CFG_OVERLOAD:     over_pct  = value & 'hFF;
      default:          idle_thr  = value & 'hFF;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all_regs(bit [15:0] per, bit [15:0] mn, bit [15:0] mx,
                                bit [15:0] gd, bit [15:0] bs, bit [15:0] ov,
                                bit [15:0] id);
    write_reg(CFG_FRAME_PERIOD, per);
    write_reg(CFG_SLOT_MIN, mn);
    write_reg(CFG_SLOT_MAX, mx);
    write_reg(CFG_GUARD, gd);
    write_reg(CFG_BASE_SLOT, bs);
    write_reg(CFG_OVERLOAD, ov);
    write_reg(CFG_IDLE, id);
  endtask

  // tracker of a random live entry, or a random id when the random picks hit no live entry
  function automatic bit [7:0] live_tracker();
    int i;
    for (int t = 0; t < 16; t++) begin
      i = $urandom_range(0, NSLOT - 1);
      if (slot_act[i]) return slot_trk[i];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // random operation, mostly aimed at live trackers
  task automatic send_random_op();
    int     pick;
    op_t    op;
    bit [7:0] id;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) clock_us = $urandom();
    else if ($urandom_range(0, 9) == 0) clock_us += $urandom_range(20000, 80000);
    else clock_us += $urandom_range(0, 3000);
    if (pick < 20)      op = OP_REGISTER;
    else if (pick < 35) op = OP_UNREGISTER;
    else if (pick < 85) op = OP_REPORT;
    else                op = OP_FRAME;
    // noise: id anywhere in range, may miss or duplicate
    if (op == OP_REGISTER || $urandom_range(0, 9) == 0) id = 8'($urandom_range(0, 255));
    else id = live_tracker();
    send_op(op, clock_us, id, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
            ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
  endtask

  task automatic test_directed_ops();
    send_op(OP_FRAME, 32'd0, 8'd0, 2'd0, 1'b0, 16'd0);
    send_op(OP_REPORT, 32'd10, 8'd7, 2'd0, 1'b1, 16'd5);      // nothing registered
    send_op(OP_UNREGISTER, 32'd20, 8'd7, 2'd0, 1'b0, 16'd0);  // empty table
    send_op(OP_REGISTER, 32'd100, 8'd0, 2'd0, 1'b0, 16'd0);
    send_op(OP_REGISTER, 32'd200, 8'd255, 2'd1, 1'b0, 16'd0);
    send_op(OP_REGISTER, 32'd300, 8'd33, 2'd2, 1'b0, 16'd0);
    send_op(OP_REGISTER, 32'd400, 8'd33, 2'd3, 1'b0, 16'd0);  // duplicate id
    send_op(OP_REPORT, 32'd9000, 8'd33, 2'd0, 1'b0, 16'hFFFF);
    send_op(OP_REPORT, 32'd9100, 8'd255, 2'd0, 1'b1, 16'd0);
    send_op(OP_REPORT, 32'hFFFF_FFFF, 8'd0, 2'd3, 1'b0, 16'd1);
    send_op(OP_FRAME, 32'hFFFF_FFF0, 8'd0, 2'd0, 1'b1, 16'd0);
    send_op(OP_REPORT, 32'h0000_1000, 8'd0, 2'd0, 1'b1, 16'd300); // time wrap
    // fill the table and try one more
    for (int i = 0; i < 13; i++)
      send_op(OP_REGISTER, 32'h2000 + i * 50, 8'(100 + i), 2'(i), 1'b0, 16'd0);
    send_op(OP_REGISTER, 32'h3000, 8'd200, 2'd3, 1'b0, 16'd0);
    send_op(OP_UNREGISTER, 32'h3100, 8'd33, 2'd0, 1'b0, 16'd0);
    send_op(OP_REGISTER, 32'h3200, 8'd44, 2'd3, 1'b0, 16'd0);   // reuses retx entry
    send_op(OP_UNREGISTER, 32'h3300, 8'd201, 2'd0, 1'b0, 16'd0);
    drain_results();
  endtask

  // zero period, min above max, both thresholds met, largest guard and base
  task automatic test_config_extremes();
    write_all_regs(16'd0, 16'hFFFF, 16'd0, 16'd255, 16'h03FF, 16'd0, 16'd255);
    for (int i = 0; i < 12; i++) send_random_op();
    drain_results();
    write_all_regs(16'hFFFF, 16'd0, 16'h03FF, 16'd0, 16'd0, 16'd255, 16'd0);
    for (int i = 0; i < 12; i++) send_random_op();
    drain_results();
    write_all_regs(16'd1000, 16'd100, 16'h03FF, 16'd200, 16'h03FF, 16'd5, 16'd250);
    for (int i = 0; i < 12; i++) send_random_op();
    drain_results();
  endtask

  // repeated failures on one tracker push its retry count past saturation
  task automatic test_retry_saturation();
    bit [7:0] id;
    id = live_tracker();
    send_op(OP_REGISTER, clock_us, id, 2'd2, 1'b0, 16'd0);
    id = live_tracker();
    for (int i = 0; i < 260; i++) begin
      clock_us += $urandom_range(0, 400);
      send_op(OP_REPORT, clock_us, id, 2'd0, 1'b0, 16'($urandom_range(0, 65535)));
    end
    send_op(OP_REPORT, clock_us + 5, id, 2'd0, 1'b1, 16'd17);
    drain_results();
  endtask

  // long receiver hold-off while words keep coming, then a full pause
  task automatic test_backpressure();
    @(posedge clk);
    rx_hold_left = 600;
    for (int i = 0; i < 8; i++) send_random_op();
    drain_results();
  endtask

  task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) send_random_op();
    drain_results();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = OP_REGISTER;
    in_now_us    = '0;
    in_tracker   = '0;
    in_prio      = '0;
    in_tx_ok     = 1'b0;
    in_latency   = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_FRAME_PERIOD;
    cfg_data     = '0;
    err_count    = 0;
    quiet_cycles = 0;
    rx_hold_left = 0;
    clock_us     = 0;
    tx_idle_pct  = 12;
    rx_idle_pct  = 63;
    // mirror starts at the reset state and reset register values
    for (int i = 0; i < NSLOT; i++) begin
      slot_act[i] = 0; slot_trk[i] = 0; slot_pri[i] = 0; slot_dur[i] = 0;
      slot_last[i] = 0; slot_succ[i] = 0; slot_retries[i] = 0; slot_retx[i] = 0;
    end
    n_active = 0; frame_origin_us = 0; frames_seen = 0;
    util_now = 0; lat_avg = 0; lat_max = 0;
    period_us = 5000; min_us = 200; max_us = 1000; guard = 50;
    base_us = 300; over_pct = 90; idle_thr = 70;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_ops();
    test_config_extremes();
    write_all_regs(16'd5000, 16'd200, 16'd1000, 16'd50, 16'd300, 16'd90, 16'd70);
    test_retry_saturation();
    test_backpressure();
    test_random_traffic(480, 12, 63);
    write_all_regs(16'd3000, 16'd150, 16'd900, 16'd20, 16'd400, 16'd60, 16'd40);
    test_random_traffic(480, 63, 12);
    write_all_regs(16'd8000, 16'd300, 16'd700, 16'd100, 16'd250, 16'd120, 16'd90);
    test_random_traffic(480, 0, 0);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
